// ===== sv/pcc_pkg.sv =====
`timescale 1ns / 1ps

package pcc_pkg;

    // coordinate and arithmetic widths
    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int NUM_TRI     = 3;

    // vertex count codes (saturating)
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_FULL = 2'd3;

    // triple slots: running turn, two wrap-around turns
    localparam int TRI_RUN   = 0;
    localparam int TRI_WRAP0 = 1;
    localparam int TRI_WRAP1 = 2;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]      t_diff;
    typedef logic signed [PROD_W-1:0]      t_prod;

    // edge vectors of one triple (a, b, c), all relative to a
    typedef struct packed {
        t_diff bx_ax;
        t_diff cy_ay;
        t_diff by_ay;
        t_diff cx_ax;
    } t_tri;

    // the two halves of one cross product
    typedef struct packed {
        t_prod p;
        t_prod q;
    } t_cross;

    // per-item control carried down the pipe
    typedef struct packed {
        logic valid;
        logic last;
        logic do_turn;
        logic turn_ref;
        logic do_wrap;
    } t_ctl;

    // exact difference of two coordinates, one bit wider
    function automatic t_diff coord_sub(t_coord a, t_coord b);
        return t_diff'(a) - t_diff'(b);
    endfunction

endpackage

// ===== sv/polygon_concavity_check.sv =====
`timescale 1ns / 1ps

// channel  | direction | handshake                | payload
// vertex   | in        | i_in_valid / o_in_stall  | i_point_x, i_point_y, i_last_point
// result   | out       | o_out_valid / i_out_stall| o_concave
//
// one vertex accepted per cycle while o_in_stall is low; once its last vertex is accepted, a
// result passes through the difference stage, multiply stage and compare stage in that order
// the three-stage pipe moves as a whole and holds only while a result waits
// under i_out_stall; o_in_stall follows that hold
// i_rst_n is synchronous, active low, and clears the vertex count, the pipe
// valids, the sign state and the result valid

module polygon_concavity_check
    import pcc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [COORD_WIDTH-1:0] i_point_x,
    input  logic [COORD_WIDTH-1:0] i_point_y,
    input  logic                   i_last_point,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_concave
);

    logic   pipe_en;
    logic   in_acc;
    t_coord x_in;
    t_coord y_in;

    // vertex history
    logic [1:0] r_count;
    t_coord     r_first_x, r_first_y, r_second_x, r_second_y;
    t_coord     r_older_x, r_older_y, r_newer_x, r_newer_y;

    // stage registers
    t_ctl   r_s1_ctl;
    t_tri   r_s1_tri [NUM_TRI];
    t_ctl   r_s2_ctl;
    t_cross r_s2_crs [NUM_TRI];

    // sign state and result
    logic r_ref;
    logic r_mis;
    logic r_out_valid;
    logic r_concave;

    t_ctl   n_s1_ctl;
    t_tri   n_s1_tri [NUM_TRI];
    t_cross n_s2_crs [NUM_TRI];
    logic   neg [NUM_TRI];
    logic   ref_eff;
    logic   n_mis;

    // pipe holds only while a result waits under stall
    assign pipe_en    = !r_out_valid || !i_out_stall;
    assign o_in_stall = !pipe_en;
    assign in_acc     = i_in_valid && pipe_en;
    assign x_in       = t_coord'(i_point_x);
    assign y_in       = t_coord'(i_point_y);

    // edge vectors for the running triple and both wrap-around triples
    always_comb begin
        n_s1_tri[TRI_RUN].bx_ax   = coord_sub(r_newer_x, r_older_x);
        n_s1_tri[TRI_RUN].cy_ay   = coord_sub(y_in, r_older_y);
        n_s1_tri[TRI_RUN].by_ay   = coord_sub(r_newer_y, r_older_y);
        n_s1_tri[TRI_RUN].cx_ax   = coord_sub(x_in, r_older_x);
        n_s1_tri[TRI_WRAP0].bx_ax = coord_sub(x_in, r_newer_x);
        n_s1_tri[TRI_WRAP0].cy_ay = coord_sub(r_first_y, r_newer_y);
        n_s1_tri[TRI_WRAP0].by_ay = coord_sub(y_in, r_newer_y);
        n_s1_tri[TRI_WRAP0].cx_ax = coord_sub(r_first_x, r_newer_x);
        n_s1_tri[TRI_WRAP1].bx_ax = coord_sub(r_first_x, x_in);
        n_s1_tri[TRI_WRAP1].cy_ay = coord_sub(r_second_y, y_in);
        n_s1_tri[TRI_WRAP1].by_ay = coord_sub(r_first_y, y_in);
        n_s1_tri[TRI_WRAP1].cx_ax = coord_sub(r_second_x, x_in);
    end

    // control for the item entering the pipe
    always_comb begin
        n_s1_ctl.valid    = in_acc;
        n_s1_ctl.last     = i_last_point;
        n_s1_ctl.do_turn  = (r_count == CNT_TWO) || (r_count == CNT_FULL);
        n_s1_ctl.turn_ref = (r_count == CNT_TWO);
        n_s1_ctl.do_wrap  = i_last_point && n_s1_ctl.do_turn;
    end

    // vertex history update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_NONE;
        end else if (in_acc) begin
            if (i_last_point) begin
                r_count <= CNT_NONE;
            end else begin
                unique case (r_count)
                    CNT_NONE: r_count <= CNT_ONE;
                    CNT_ONE:  r_count <= CNT_TWO;
                    CNT_TWO:  r_count <= CNT_FULL;
                    CNT_FULL: r_count <= CNT_FULL;
                    default:  r_count <= CNT_NONE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (r_count == CNT_NONE) begin
                r_first_x <= x_in;
                r_first_y <= y_in;
            end
            if (r_count == CNT_ONE) begin
                r_second_x <= x_in;
                r_second_y <= y_in;
            end
            r_older_x <= r_newer_x;
            r_older_y <= r_newer_y;
            r_newer_x <= x_in;
            r_newer_y <= y_in;
        end
    end

    // stage 1: differences
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (pipe_en) begin
            r_s1_ctl <= n_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s1_tri <= n_s1_tri;
        end
    end

    // stage 2: the two products of each cross product
    always_comb begin
        for (int k = 0; k < NUM_TRI; k++) begin
            n_s2_crs[k].p = t_prod'(r_s1_tri[k].bx_ax) * t_prod'(r_s1_tri[k].cy_ay);
            n_s2_crs[k].q = t_prod'(r_s1_tri[k].by_ay) * t_prod'(r_s1_tri[k].cx_ax);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else if (pipe_en) begin
            r_s2_ctl <= r_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s2_crs <= n_s2_crs;
        end
    end

    // stage 3: turn signs, reference and mismatch
    always_comb begin
        for (int k = 0; k < NUM_TRI; k++) begin
            neg[k] = r_s2_crs[k].p < r_s2_crs[k].q;
        end
        ref_eff = r_s2_ctl.turn_ref ? neg[TRI_RUN] : r_ref;
        n_mis   = r_mis
                | (r_s2_ctl.do_turn && !r_s2_ctl.turn_ref && (neg[TRI_RUN] != r_ref))
                | (r_s2_ctl.do_wrap && ((neg[TRI_WRAP0] != ref_eff)
                                     || (neg[TRI_WRAP1] != ref_eff)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref       <= 1'b0;
            r_mis       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_out_valid <= r_s2_ctl.valid && r_s2_ctl.last;
            if (r_s2_ctl.valid) begin
                if (r_s2_ctl.last) begin
                    r_ref <= 1'b0;
                    r_mis <= 1'b0;
                end else begin
                    r_ref <= ref_eff;
                    r_mis <= n_mis;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_concave <= r_s2_ctl.do_wrap && n_mis;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_concave   = r_concave;

    // a last vertex always restarts the count
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_point |=> r_count == CNT_NONE)
        else $error("count not cleared after last item");

    // the count saturates rather than wrapping
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_last_point && r_count == CNT_FULL |=> r_count == CNT_FULL)
        else $error("vertex count wrapped");

    // polygons with fewer than three vertices report convex
    a_short_convex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pipe_en && r_s2_ctl.valid && r_s2_ctl.last && !r_s2_ctl.do_wrap
        |=> o_out_valid && !o_concave)
        else $error("short polygon reported concave");

    // sign state is clear at the start of every polygon
    a_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pipe_en && r_s2_ctl.valid && r_s2_ctl.last |=> !r_mis && !r_ref)
        else $error("sign state left set after last item");

endmodule
